// ===== hdl/ipsc_pkg.sv =====
package ipsc_pkg;

  // configuration codes for the mode register
  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_TCP    = 2'd1;
  localparam logic [1:0] MODE_ICMPV6 = 2'd2;

  // input operation codes
  localparam logic OP_ADDR = 1'b0;
  localparam logic OP_DATA = 1'b1;

  // next header values of the pseudo-header
  localparam logic [15:0] NH_TCP    = 16'd6;
  localparam logic [15:0] NH_ICMPV6 = 16'd58;

  // saturation point of the payload byte count
  localparam logic [16:0] COUNT_LIMIT = 17'h10000;

  // one classified beat handed from front to back
  typedef struct packed {
    logic [15:0] word;
    logic        last;
    logic        too_long;
  } ipsc_item_t;

  // end-around fold of a sum of up to eight 16-bit words
  function automatic logic [15:0] oc_fold(input logic [18:0] s);
    logic [16:0] t;
    t = {1'b0, s[15:0]} + {14'b0, s[18:16]};
    return t[15:0] + {15'b0, t[16]};
  endfunction

endpackage

// ===== hdl/ipv6_pseudo_header_checksum_top.sv =====
// Streaming Internet checksum with optional IPv6 pseudo-header (TCP or ICMPv6).
// Accepts one beat per clock, address word or payload byte, and keeps that rate
// as long as results are taken; after its last beat a result passes a queue
// entry, then the output register, and a result held by the receiver stalls the
// input once the queue fills. The front classifies each beat and folds its words
// into one 16-bit term, a QUEUE_DEPTH-entry queue decouples it from the back
// accumulator, which adds one term per cycle unless a closing term waits for a
// free output register, which holds the result. The user must write the mode
// register via cfg_wr_en/cfg_wr_data while idle; the block does not enforce it.
module ipv6_pseudo_header_checksum_top
  import ipsc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [31:0] address_word,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] checksum,
  output logic        too_long
);

  logic       push_valid;
  logic       push_ready;
  ipsc_item_t push_item;
  logic       pop_valid;
  logic       pop_ready;
  ipsc_item_t pop_item;

  ipsc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .address_word (address_word),
    .data_byte    (data_byte),
    .last         (last),
    .push_valid   (push_valid),
    .push_item    (push_item),
    .push_ready   (push_ready)
  );

  ipsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  ipsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .checksum  (checksum),
    .too_long  (too_long)
  );

endmodule

// ===== hdl/ipsc_front.sv =====
module ipsc_front
  import ipsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             op,
  input  logic [31:0]      address_word,
  input  logic [7:0]       data_byte,
  input  logic             last,
  output logic             push_valid,
  output ipsc_item_t       push_item,
  input  logic             push_ready
);

  logic [1:0]  mode;
  logic [7:0]  pend;
  logic        odd;
  logic [16:0] count;

  logic [7:0]  pend_next;
  logic        odd_next;
  logic [16:0] count_next;
  logic        accept;
  logic        pseudo;
  logic [15:0] w_hi;
  logic [15:0] w_lo;
  logic [15:0] w_pair;
  logic [15:0] w_pad;
  logic [15:0] w_cnt_hi;
  logic [15:0] w_cnt_lo;
  logic [15:0] w_nh;
  logic [18:0] total;

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = accept;
  assign pseudo     = (mode == MODE_TCP) || (mode == MODE_ICMPV6);

  // pairing, counting and per-beat contribution
  always_comb begin
    pend_next  = pend;
    odd_next   = odd;
    count_next = count;
    w_hi       = '0;
    w_lo       = '0;
    w_pair     = '0;
    w_pad      = '0;
    w_cnt_hi   = '0;
    w_cnt_lo   = '0;
    w_nh       = '0;
    if (op == OP_ADDR) begin
      if (pseudo) begin
        w_hi = address_word[31:16];
        w_lo = address_word[15:0];
      end
    end else begin
      if (odd) begin
        w_pair   = {pend, data_byte};
        odd_next = 1'b0;
      end else begin
        pend_next = data_byte;
        odd_next  = 1'b1;
      end
      if (count < COUNT_LIMIT) begin
        count_next = count + 17'd1;
      end
    end
    // closing terms of the packet
    if (last) begin
      if (odd_next) begin
        w_pad = {pend_next, 8'h00};
      end
      if (pseudo) begin
        w_cnt_hi = {15'b0, count_next[16]};
        w_cnt_lo = count_next[15:0];
        w_nh     = (mode == MODE_TCP) ? NH_TCP : NH_ICMPV6;
      end
    end
    total = {3'b0, w_hi} + {3'b0, w_lo} + {3'b0, w_pair} + {3'b0, w_pad}
          + {3'b0, w_cnt_hi} + {3'b0, w_cnt_lo} + {3'b0, w_nh};
    push_item.word     = oc_fold(total);
    push_item.last     = last;
    push_item.too_long = count_next[16];
  end

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PLAIN;
    end else if (cfg_wr_en) begin
      mode <= cfg_wr_data;
    end
  end

  // per-packet state, cleared after the last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= '0;
      odd   <= 1'b0;
      count <= '0;
    end else if (accept) begin
      if (last) begin
        pend  <= '0;
        odd   <= 1'b0;
        count <= '0;
      end else begin
        pend  <= pend_next;
        odd   <= odd_next;
        count <= count_next;
      end
    end
  end

endmodule

// ===== hdl/ipsc_queue.sv =====
module ipsc_queue
  import ipsc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  input  ipsc_item_t push_item,
  output logic       push_ready,
  output logic       pop_valid,
  output ipsc_item_t pop_item,
  input  logic       pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ipsc_item_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/ipsc_back.sv =====
module ipsc_back
  import ipsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  input  ipsc_item_t  pop_item,
  output logic        pop_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] checksum,
  output logic        too_long
);

  logic [15:0] acc;
  logic [15:0] sum_next;
  logic        do_pop;

  // a closing beat waits for a free output register
  assign pop_ready = !pop_item.last || !out_valid || out_ready;
  assign do_pop    = pop_valid && pop_ready;
  assign sum_next  = oc_fold({3'b0, acc} + {3'b0, pop_item.word});

  // running ones'-complement accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (do_pop) begin
      acc <= pop_item.last ? '0 : sum_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_pop && pop_item.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && pop_item.last) begin
      checksum <= pop_item.too_long ? '0 : ~sum_next;
      too_long <= pop_item.too_long;
    end
  end

endmodule

// ===== hdl/ipsc_checker.sv =====
module ipsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] checksum,
  input logic        too_long
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(checksum) && $stable(too_long))
    else $error("result beat changed while stalled");

  // an overlong packet reports a zero checksum
  a_too_long_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_long |-> checksum == 16'h0000)
    else $error("too_long result with nonzero checksum");

  // no result right after reset
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // queue is empty and open right after reset
  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind ipv6_pseudo_header_checksum_top ipsc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .checksum  (checksum),
  .too_long  (too_long)
);
